/* hw/rtl/oape_pkg.sv */
// shared constants and types for the overlap-add pcm encoder
package oape_pkg;

   localparam int MAX_CHANS = 2;
   localparam int MAX_HOP   = 256;

   localparam int CHANNEL_W  = 1;
   localparam int POSITION_W = 9;
   localparam int VALUE_W    = 32;
   localparam int OUT_POS_W  = 8;
   localparam int CLIP_W     = 16;
   localparam int PCM_W      = 32;

   localparam int DEPTH_W     = 2;
   localparam int HOP_W       = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 1;

   localparam int TAIL_DEPTH  = MAX_CHANS * MAX_HOP;
   localparam int TAIL_ADDR_W = (TAIL_DEPTH > 1) ? $clog2(TAIL_DEPTH) : 1;
   localparam int OFFSET_W    = (MAX_HOP > 1) ? $clog2(MAX_HOP) : 1;
   localparam int CLR_W       = $clog2(TAIL_DEPTH + 1);

   localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(256);

   localparam int CLIP_MAX  = 32767;
   localparam int CLIP_MIN  = -32768;
   localparam int U8_OFFSET = 128;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_DEPTH  = 1'b0,
      CSR_HOP_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [DEPTH_W-1:0] {
      DEPTH_U8  = 2'd0,
      DEPTH_S16 = 2'd1,
      DEPTH_S24 = 2'd2,
      DEPTH_S32 = 2'd3
   } bit_depth_type;

endpackage

/* hw/rtl/oape_req_if.sv */
// request channel: frame samples into the encoder
interface oape_req_if;
   import oape_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CHANNEL_W-1:0]         channel;
   logic [POSITION_W-1:0]        position;
   logic signed [VALUE_W-1:0]    value;

   modport source (output valid, channel, position, value, input ready);
   modport sink   (input valid, channel, position, value, output ready);
endinterface

/* hw/rtl/oape_rsp_if.sv */
// response channel: finished pcm samples out of the encoder
interface oape_rsp_if;
   import oape_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [CHANNEL_W-1:0]         out_channel;
   logic [OUT_POS_W-1:0]         out_position;
   logic signed [CLIP_W-1:0]     clipped_sample;
   logic [PCM_W-1:0]             pcm_word;

   modport source (output valid, out_channel, out_position, clipped_sample, pcm_word,
                   input ready);
   modport sink   (input valid, out_channel, out_position, clipped_sample, pcm_word,
                   output ready);
endinterface

/* hw/rtl/overlap_add_pcm_encoder_core.sv */
// top level of the streaming overlap-add pcm encoder
// Takes one frame sample per cycle while rsp_bus does not stall, and presents each
// finished pcm sample on rsp_bus once its request has passed the register stages;
// the pipeline is classify and tail ram access, then the 33-bit overlap add, then
// saturate and encode, with one register stage each. The rate is set by the tail ram,
// which takes one write (second-half samples) and one read (first-half samples) per
// cycle, so any mix of positions streams at one request per cycle unless rsp_bus
// stalls. After reset the tail ram is swept to zero, one entry per cycle, over all 512
// entries (channels times maximum hop), during which req_bus.ready stays low; configuration
// writes are taken at any time and must only be issued while the pipeline is empty.
module overlap_add_pcm_encoder_core (
   input  logic                               clock,
   input  logic                               reset,
   oape_req_if.sink                           req_bus,
   oape_rsp_if.source                         rsp_bus,
   input  logic                               csr_write,
   input  oape_pkg::csr_index_type            csr_index,
   input  logic [oape_pkg::CSR_DATA_W-1:0]    csr_data
);
   import oape_pkg::*;

   localparam logic signed [VALUE_W:0] SUM_MAX = (VALUE_W+1)'(CLIP_MAX);
   localparam logic signed [VALUE_W:0] SUM_MIN = (VALUE_W+1)'(CLIP_MIN);

   // configuration
   bit_depth_type           bit_depth_ff;
   logic [HOP_W-1:0]        hop_ff;

   // clearing sweep
   logic [CLR_W-1:0]        clr_ff;
   logic [CLR_W-1:0]        clr_in;
   logic                    clearing;

   // classification
   logic [HOP_W-1:0]        hop_eff;
   logic [HOP_W:0]          frame_len;
   logic                    in_range;
   logic                    is_head;
   logic                    ch_ok;
   logic [POSITION_W-1:0]   tail_off;
   logic [OFFSET_W-1:0]     offset;
   logic [TAIL_ADDR_W-1:0]  tail_addr;
   logic                    accept;
   logic                    head_acc;
   logic                    tail_acc;

   // ram ports
   logic                    ram_we;
   logic [TAIL_ADDR_W-1:0]  ram_waddr;
   logic [VALUE_W-1:0]      ram_wdata;
   logic [VALUE_W-1:0]      tail_rd;

   // pipeline control
   logic                    s1_en;
   logic                    s2_en;
   logic                    s3_en;

   // stage 1: sample and tail read
   logic                    v1_ff, v1_in;
   logic [CHANNEL_W-1:0]    ch1_ff;
   logic [OUT_POS_W-1:0]    pos1_ff;
   logic signed [VALUE_W-1:0] val1_ff;

   // stage 2: overlap sum
   logic                    v2_ff, v2_in;
   logic [CHANNEL_W-1:0]    ch2_ff;
   logic [OUT_POS_W-1:0]    pos2_ff;
   logic signed [VALUE_W:0] sum2_ff, sum2_in;

   // stage 3: output register
   logic                    v3_ff, v3_in;
   logic [CHANNEL_W-1:0]    ch3_ff;
   logic [OUT_POS_W-1:0]    pos3_ff;
   logic signed [CLIP_W-1:0] clip3_ff, clip3_in;
   logic [PCM_W-1:0]        pcm3_ff, pcm3_in;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_depth_ff <= DEPTH_S16;
         hop_ff       <= HOP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_DEPTH:  bit_depth_ff <= bit_depth_type'(csr_data[DEPTH_W-1:0]);
            CSR_HOP_LENGTH: hop_ff       <= csr_data[HOP_W-1:0];
            default:        ;
         endcase
      end
   end

   // ---------------- clearing sweep ----------------
   assign clearing = (clr_ff != CLR_W'(TAIL_DEPTH));
   assign clr_in   = clearing ? clr_ff + CLR_W'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // ---------------- classify request ----------------
   always_comb begin
      if (hop_ff == '0) begin
         hop_eff = HOP_W'(1);
      end else if (hop_ff > HOP_W'(MAX_HOP)) begin
         hop_eff = HOP_W'(MAX_HOP);
      end else begin
         hop_eff = hop_ff;
      end
   end

   assign frame_len = {1'b0, hop_eff} << 1;
   assign in_range  = ({1'b0, req_bus.position} < frame_len);
   assign is_head   = (req_bus.position < hop_eff);
   assign ch_ok     = (int'(req_bus.channel) < MAX_CHANS);
   assign tail_off  = req_bus.position - hop_eff;
   assign offset    = is_head ? req_bus.position[OFFSET_W-1:0] : tail_off[OFFSET_W-1:0];
   assign tail_addr = TAIL_ADDR_W'(int'(req_bus.channel) * MAX_HOP + int'(offset));

   assign s3_en = !v3_ff || rsp_bus.ready;
   assign s2_en = !v2_ff || s3_en;
   assign s1_en = !v1_ff || s2_en;

   assign req_bus.ready = !clearing && s1_en;
   assign accept        = req_bus.valid && req_bus.ready;
   assign head_acc      = accept && ch_ok && in_range && is_head;
   assign tail_acc      = accept && ch_ok && in_range && !is_head;

   // second-half samples are written at acceptance, so a later head read always sees them
   assign ram_we    = clearing || tail_acc;
   assign ram_waddr = clearing ? clr_ff[TAIL_ADDR_W-1:0] : tail_addr;
   assign ram_wdata = clearing ? '0 : req_bus.value;

   oape_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TAIL_DEPTH)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (head_acc),
      .rd_addr (tail_addr),
      .rd_data (tail_rd)
   );

   // ---------------- stage 1 ----------------
   assign v1_in = s1_en ? head_acc : v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      if (head_acc) begin
         ch1_ff  <= req_bus.channel;
         pos1_ff <= req_bus.position[OUT_POS_W-1:0];
         val1_ff <= req_bus.value;
      end
   end

   // ---------------- stage 2 ----------------
   assign v2_in   = s2_en ? v1_ff : v2_ff;
   assign sum2_in = {val1_ff[VALUE_W-1], val1_ff} + {tail_rd[VALUE_W-1], tail_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      if (s2_en) begin
         ch2_ff  <= ch1_ff;
         pos2_ff <= pos1_ff;
         sum2_ff <= sum2_in;
      end
   end

   // ---------------- stage 3: saturate and encode ----------------
   always_comb begin
      if (sum2_ff > SUM_MAX) begin
         clip3_in = CLIP_W'(CLIP_MAX);
      end else if (sum2_ff < SUM_MIN) begin
         clip3_in = CLIP_W'(CLIP_MIN);
      end else begin
         clip3_in = sum2_ff[CLIP_W-1:0];
      end
   end

   always_comb begin
      case (bit_depth_ff)
         // unsigned 8-bit: offset binary of the low byte
         DEPTH_U8:  pcm3_in = {24'b0, clip3_in[7:0] + 8'(U8_OFFSET)};
         DEPTH_S16: pcm3_in = {16'b0, clip3_in};
         DEPTH_S24: pcm3_in = {8'b0, clip3_in, 8'b0};
         default:   pcm3_in = {clip3_in, 16'b0};
      endcase
   end

   assign v3_in = s3_en ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
      end
      if (s3_en) begin
         ch3_ff   <= ch2_ff;
         pos3_ff  <= pos2_ff;
         clip3_ff <= clip3_in;
         pcm3_ff  <= pcm3_in;
      end
   end

   assign rsp_bus.valid          = v3_ff;
   assign rsp_bus.out_channel    = ch3_ff;
   assign rsp_bus.out_position   = pos3_ff;
   assign rsp_bus.clipped_sample = clip3_ff;
   assign rsp_bus.pcm_word       = pcm3_ff;

endmodule

/* hw/rtl/oape_ram.sv */
// generic simple dual-port ram with registered read
module oape_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* dv/tb_overlap_add_pcm_encoder_core.sv */
// self-checking testbench for the overlap-add pcm encoder core
`timescale 1ns / 1ps

module tb_overlap_add_pcm_encoder_core;
   import oape_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHANNEL_W-1:0]     channel;
      logic [OUT_POS_W-1:0]     position;
      logic signed [CLIP_W-1:0] sample;
      logic [PCM_W-1:0]         pcm;
   } pcm_result_type;

   // overlap-add predictor with its own tail memory and the queue of pcm samples due
   class pcm_scoreboard;
      logic signed [VALUE_W-1:0] tail_mem [TAIL_DEPTH];
      bit_depth_type             depth;
      logic [HOP_W-1:0]          hop;
      pcm_result_type            due_q [$];
      int                        errors;
      int                        requests;
      int                        tail_writes;
      int                        out_of_frame;
      int                        samples_checked;

      function new();
         foreach (tail_mem[i]) tail_mem[i] = '0;
         depth = DEPTH_S16;
         hop = HOP_RESET;
         errors = 0;
         requests = 0;
         tail_writes = 0;
         out_of_frame = 0;
         samples_checked = 0;
      endfunction

      function void configure(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BIT_DEPTH:  depth = bit_depth_type'(data[DEPTH_W-1:0]);
            CSR_HOP_LENGTH: hop = data[HOP_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [CHANNEL_W-1:0] ch, logic [POSITION_W-1:0] pos,
                                 logic signed [VALUE_W-1:0] val);
         int             span;
         int             slot;
         longint         total;
         int             clip;
         logic [15:0]    c16;
         pcm_result_type due;
         span = (hop == 0) ? 1 : ((int'(hop) > MAX_HOP) ? MAX_HOP : int'(hop));
         requests++;
         if (int'(ch) >= MAX_CHANS || int'(pos) >= 2 * span) begin
            out_of_frame++;
            return;
         end
         // second half of the frame becomes the tail for the next one
         if (int'(pos) >= span) begin
            tail_mem[int'(ch) * MAX_HOP + int'(pos) - span] = val;
            tail_writes++;
            return;
         end
         slot = int'(ch) * MAX_HOP + int'(pos);
         total = longint'(val) + longint'(tail_mem[slot]);
         if (total > CLIP_MAX) total = CLIP_MAX;
         if (total < CLIP_MIN) total = CLIP_MIN;
         clip = int'(total);
         c16 = 16'(clip);
         due.channel = ch;
         due.position = pos[OUT_POS_W-1:0];
         due.sample = c16;
         case (depth)
            DEPTH_U8:  due.pcm = {24'b0, 8'(clip + U8_OFFSET)};
            DEPTH_S16: due.pcm = {16'b0, c16};
            DEPTH_S24: due.pcm = {8'b0, c16, 8'b0};
            default:   due.pcm = {c16, 16'b0};
         endcase
         due_q.push_back(due);
      endfunction

      function void check_result(pcm_result_type got);
         pcm_result_type due;
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected pcm sample: ch %0d pos %0d clip %0d pcm %h",
                        got.channel, got.position, got.sample, got.pcm);
            return;
         end
         due = due_q.pop_front();
         samples_checked++;
         if (got.channel !== due.channel || got.position !== due.position ||
             got.sample !== due.sample || got.pcm !== due.pcm) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display("mismatch: expected ch %0d pos %0d clip %0d pcm %h",
                        due.channel, due.position, due.sample, due.pcm);
               $display("          got      ch %0d pos %0d clip %0d pcm %h",
                        got.channel, got.position, got.sample, got.pcm);
            end
         end
      endfunction

      function int pending();
         return due_q.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    csr_write;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   oape_req_if req_bus ();
   oape_rsp_if rsp_bus ();

   pcm_scoreboard sb;
   bit            no_idle;
   int            hold_off_cycles;
   int            cycle_count;
   int            settings_run;

   overlap_add_pcm_encoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_overlap_add_pcm_encoder_core failed");
      $finish;
   end

   // one request: optional gap, then hold valid until the core takes it
   task automatic send_request(logic [CHANNEL_W-1:0] ch, logic [POSITION_W-1:0] pos,
                               logic signed [VALUE_W-1:0] val);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.channel = ch;
      req_bus.position = pos;
      req_bus.value = val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(ch, pos, val);
      @(negedge clock);
   endtask

   // let every due sample come out and the pipeline empty before touching registers
   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(negedge clock);
      csr_write = 1'b0;
      sb.configure(idx, data);
   endtask

   task automatic set_mode(bit_depth_type d, logic [HOP_W-1:0] h);
      drain();
      write_csr(CSR_BIT_DEPTH, CSR_DATA_W'(d));
      write_csr(CSR_HOP_LENGTH, CSR_DATA_W'(h));
      settings_run++;
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 80000) - 40000;
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'sd32767;
               default: return -32'sd32768;
            endcase
         end
         default: return $urandom_range(0, 40000) - 20000;
      endcase
   endfunction

   // mostly whole frames in order, the rest scattered positions including out of frame
   task automatic run_phase(bit_depth_type d, logic [HOP_W-1:0] h, int count, bit busy,
                            bit squeeze);
      int                   span;
      int                   sent;
      logic [CHANNEL_W-1:0] ch;
      set_mode(d, h);
      span = (h == 0) ? 1 : ((int'(h) > MAX_HOP) ? MAX_HOP : int'(h));
      no_idle = busy;
      if (squeeze) hold_off_cycles = HOLD_CYCLES;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 6) begin
            ch = CHANNEL_W'($urandom);
            for (int p = 0; p < 2 * span && sent < count; p++) begin
               send_request(ch, POSITION_W'(p), draw_value());
               sent++;
            end
         end else begin
            send_request(CHANNEL_W'($urandom), POSITION_W'($urandom_range(0, 511)),
                         draw_value());
            sent++;
         end
      end
      no_idle = 1'b0;
   endtask

   // response side: random stalls, one long hold-off when asked
   initial begin
      int             stall;
      int             held;
      pcm_result_type got;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            held = 0;
            while (held < hold_off_cycles) begin
               @(negedge clock);
               held++;
            end
            hold_off_cycles = 0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.channel = rsp_bus.out_channel;
         got.position = rsp_bus.out_position;
         got.sample = rsp_bus.clipped_sample;
         got.pcm = rsp_bus.pcm_word;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      sb = new();
      no_idle = 1'b0;
      hold_off_cycles = 0;
      settings_run = 1;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_BIT_DEPTH;
      csr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.channel = '0;
      req_bus.position = '0;
      req_bus.value = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // reset settings: 16-bit, full hop
      send_request(1'b0, 9'd0, 32'sd0);
      send_request(1'b1, 9'd255, 32'h7FFF_FFFF);
      send_request(1'b0, 9'd1, 32'h8000_0000);
      send_request(1'b0, 9'd261, 32'h7FFF_FFFF);
      send_request(1'b0, 9'd5, 32'h7FFF_FFFF);
      send_request(1'b1, 9'd262, 32'h8000_0000);
      send_request(1'b1, 9'd6, 32'h8000_0000);
      send_request(1'b1, 9'd511, -32'sd100);
      send_request(1'b1, 9'd255, 32'sd50);
      // tail survives a read
      send_request(1'b0, 9'd5, 32'h8000_0001);
      send_request(1'b0, 9'd300, 32'sd32767);
      send_request(1'b0, 9'd44, 32'sd1);

      // zero hop acts as one; positions past the frame are dropped
      set_mode(DEPTH_U8, 9'd0);
      send_request(1'b0, 9'd0, -32'sd32768);
      send_request(1'b0, 9'd1, 32'sd5);
      send_request(1'b0, 9'd0, 32'sd10);
      send_request(1'b1, 9'd2, 32'sd77);
      send_request(1'b0, 9'd511, 32'sd99);
      send_request(1'b0, 9'd0, 32'sd32767);

      // hop above the maximum acts as the maximum
      set_mode(DEPTH_S24, 9'd511);
      send_request(1'b1, 9'd300, -32'sd7);
      send_request(1'b1, 9'd44, 32'sd3);

      set_mode(DEPTH_S32, 9'd256);
      send_request(1'b0, 9'd255, -32'sd1);
      send_request(1'b1, 9'd128, 32'sd1234);

      run_phase(DEPTH_S16, 9'd256, 400, 1'b1, 1'b1);
      run_phase(DEPTH_U8, 9'd1, 200, 1'b0, 1'b0);
      run_phase(DEPTH_S24, 9'd4, 200, 1'b1, 1'b0);
      run_phase(DEPTH_S32, 9'd16, 200, 1'b0, 1'b0);
      run_phase(DEPTH_U8, 9'd0, 150, 1'b0, 1'b0);
      run_phase(DEPTH_S32, 9'd511, 200, 1'b1, 1'b0);
      run_phase(DEPTH_S24, HOP_W'($urandom_range(1, 256)), 200, 1'b0, 1'b0);
      run_phase(DEPTH_S16, 9'd2, 200, 1'b0, 1'b0);
      run_phase(bit_depth_type'($urandom_range(0, 3)), HOP_W'($urandom_range(1, 64)), 175,
                1'b0, 1'b0);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests over %0d register settings: %0d tail writes, %0d out of frame",
               sb.requests, settings_run, sb.tail_writes, sb.out_of_frame);
      $display("%0d pcm samples checked, %0d errors, %0d still due",
               sb.samples_checked, sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_overlap_add_pcm_encoder_core passed");
      end else begin
         $display("tb_overlap_add_pcm_encoder_core failed");
      end
      $finish;
   end

endmodule
